### hw/rtl/config_command_transaction_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the config command transaction sequencer
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CONFIG_COMMAND_TRANSACTION_SEQUENCER_MACROS_SVH
`define CONFIG_COMMAND_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication, off while in reset
`define CCTS_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// next-cycle implication, off while in reset
`define CCTS_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

### hw/rtl/ccts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccts_pkg
// Types, codes and constants of the config command transaction sequencer.
// ----------------------------------------------------------------------------
package ccts_pkg;

  // special ack words
  localparam logic [15:0] ENABLE_ACK  = 16'h01FF;
  localparam logic [15:0] DISABLE_ACK = 16'h01FE;
  localparam logic [15:0] ACK_BIT     = 16'h0100;

  // config port geometry and reset values
  localparam int          CFG_IDX_W        = 1;
  localparam int          CFG_DATA_W       = 16;
  localparam int          RETRY_W          = 4;
  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd1000;
  localparam logic [3:0]  MAX_RETRIES_RST  = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACK_TIMEOUT = 1'b0,
    CFG_MAX_RETRIES = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_ACK     = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    EV_ENABLE   = 3'd0,
    EV_CMD      = 3'd1,
    EV_DISABLE  = 3'd2,
    EV_DROP     = 3'd3,
    EV_OVERFLOW = 3'd4
  } event_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_WAIT_EN  = 4'b0010,
    PH_WAIT_CMD = 4'b0100,
    PH_WAIT_DIS = 4'b1000
  } phase_t;

  // one queued command
  typedef struct packed {
    logic        has_value;
    logic [15:0] value;
    logic [15:0] word;
  } cmd_t;

  // queue control and status
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // one result item
  typedef struct packed {
    event_t      event_res;
    logic [15:0] frame_word;
    logic [15:0] frame_value;
    logic        frame_has_value;
    logic [15:0] timeouts_seen;
    logic [15:0] failures_seen;
    logic [15:0] last_failed_word;
    logic        session_open;
  } result_t;

  // saturating increment of a 16-bit counter
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

### hw/rtl/ccts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccts_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ccts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccts_fifo
// Command queue. A push into a full queue drops the oldest entry. The head
// entry is always presented; the RAM is read ahead at the next head address
// and a same-cycle write to that address is bypassed.
// ----------------------------------------------------------------------------
module ccts_fifo
  import ccts_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_ctrl_t ctl,
  input  cmd_t       push_data,
  output fifo_stat_t stat,
  output cmd_t       head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(cmd_t);

  logic [AW-1:0] head_r, head_nxt, head_inc, waddr;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW:0]   tail_sum;
  logic          we;
  logic          byp_r, byp_nxt;
  cmd_t          byp_data_r;
  logic [EW-1:0] ram_rdata;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

  // wrap-around head increment and tail address
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = {1'b0, head_r} + {1'b0, count_r[AW-1:0]};

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    we        = 1'b0;
    waddr     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                              : tail_sum[AW-1:0];
    if (ctl.push) begin
      we = 1'b1;
      if (stat.full) begin
        // oldest entry is dropped, its slot takes the new one
        waddr    = head_r;
        head_nxt = head_inc;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (ctl.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - 1'b1;
    end
    byp_nxt = we && (waddr == head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      byp_r   <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= push_data;
  end

  ccts_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_data),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  assign head = byp_r ? byp_data_r : cmd_t'(ram_rdata);

endmodule

### hw/rtl/config_command_transaction_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_command_transaction_sequencer
// Queues configuration commands and sequences each one as enable-config,
// command, disable-config frames with ack wait, timeout and retries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per accept:
//   a tick, an enqueue or a received ack. Output channel (out_valid /
//   out_stall) carries at most one event per input request: a frame to send,
//   a dropped command or a queue overflow, plus the running counters.
//   Configuration (cfg_we / cfg_index / cfg_wdata) sets the ack timeout and
//   the retry budget; write it only while the block is idle.
//   Each event is registered in the result or skid register. Throughput: one
//   request per cycle while in_stall is low; all decisions are made in a
//   single combinational pass from the state registers to the result register.
//   A two-entry output buffer (result register plus skid register) lets a
//   request be taken while one result waits; in_stall rises only when both
//   entries hold results, and falls as soon as the receiver takes one.
//   Reset (rst_n low, synchronous) empties the queue, clears all counters
//   and flags, and restores a timeout of 1000 ticks and 3 retries.
// ----------------------------------------------------------------------------
module config_command_transaction_sequencer
  import ccts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [15:0]           in_cmd_word,
  input  logic [15:0]           in_cmd_value,
  input  logic                  in_cmd_has_value,
  input  logic [15:0]           in_ack_word,
  input  logic [7:0]            in_ack_status,
  // event channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_res,
  output logic [15:0]           out_frame_word,
  output logic [15:0]           out_frame_value,
  output logic                  out_frame_has_value,
  output logic [15:0]           out_timeouts_seen,
  output logic [15:0]           out_failures_seen,
  output logic [15:0]           out_last_failed_word,
  output logic                  out_session_open,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [15:0]        ack_timeout_r;
  logic [RETRY_W-1:0] max_retries_r;

  // sequencer state
  cmd_t               active_r, active_nxt;
  logic               has_active_r, has_active_nxt;
  phase_t             phase_r, phase_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic               session_r, session_nxt;
  logic               drop_close_r, drop_close_nxt;
  logic [15:0]        expected_r, expected_nxt;
  logic [15:0]        ticks_r, ticks_nxt;
  logic               ack_latched_r, ack_latched_nxt;
  logic [15:0]        ack_word_r, ack_word_nxt;
  logic [7:0]         ack_status_r, ack_status_nxt;
  logic [15:0]        tmo_cnt_r, tmo_cnt_nxt;
  logic [15:0]        fail_cnt_r, fail_cnt_nxt;
  logic [15:0]        last_failed_r, last_failed_nxt;

  // queue
  fifo_ctrl_t         fctl;
  fifo_stat_t         fstat;
  cmd_t               fifo_head;
  cmd_t               in_cmd;

  // result path
  result_t            res;
  logic               res_valid;
  result_t            out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               out_take;
  logic               in_acc;
  logic               ack_hit, tick_expired;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  assign in_cmd.word      = in_cmd_word;
  assign in_cmd.value     = in_cmd_value;
  assign in_cmd.has_value = in_cmd_has_value;

  assign ack_hit      = ack_latched_r && (ack_word_r == expected_r);
  assign tick_expired = (ticks_r <= 16'd1);

  ccts_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fctl),
    .push_data (in_cmd),
    .stat      (fstat),
    .head      (fifo_head)
  );

  // sequencer step for one request
  always_comb begin
    logic stage_fail;
    logic do_drop;
    logic go_idle;
    logic send_en;
    logic send_cmd;
    logic send_dis;
    logic overflow;

    stage_fail = 1'b0;
    do_drop    = 1'b0;
    go_idle    = 1'b0;
    send_en    = 1'b0;
    send_cmd   = 1'b0;
    send_dis   = 1'b0;
    overflow   = 1'b0;

    active_nxt      = active_r;
    has_active_nxt  = has_active_r;
    phase_nxt       = phase_r;
    retry_nxt       = retry_r;
    session_nxt     = session_r;
    drop_close_nxt  = drop_close_r;
    expected_nxt    = expected_r;
    ticks_nxt       = ticks_r;
    ack_latched_nxt = ack_latched_r;
    ack_word_nxt    = ack_word_r;
    ack_status_nxt  = ack_status_r;
    tmo_cnt_nxt     = tmo_cnt_r;
    fail_cnt_nxt    = fail_cnt_r;
    last_failed_nxt = last_failed_r;
    fctl            = '0;

    res.event_res       = EV_ENABLE;
    res.frame_word      = '0;
    res.frame_value     = '0;
    res.frame_has_value = 1'b0;

    if (in_acc) begin
      unique case (opcode_t'(in_opcode))
        OP_TICK: begin
          unique case (phase_r) inside
            PH_IDLE: begin
              if (has_active_r || !fstat.empty) begin
                if (!has_active_r) begin
                  active_nxt = fifo_head;
                  fctl.pop   = 1'b1;
                end
                has_active_nxt = 1'b1;
                retry_nxt      = '0;
                drop_close_nxt = 1'b0;
                send_en        = 1'b1;
              end
            end
            PH_WAIT_EN, PH_WAIT_CMD: begin
              ack_latched_nxt = 1'b0;
              if (ack_hit) begin
                if (ack_status_r == '0) begin
                  if (phase_r == PH_WAIT_EN) begin
                    session_nxt = 1'b1;
                    send_cmd    = 1'b1;
                  end else begin
                    send_dis = 1'b1;
                  end
                end else begin
                  stage_fail = 1'b1;
                end
              end else if (tick_expired) begin
                ticks_nxt   = '0;
                tmo_cnt_nxt = sat_inc16(tmo_cnt_r);
                stage_fail  = 1'b1;
              end else begin
                ticks_nxt = ticks_r - 16'd1;
              end
            end
            PH_WAIT_DIS: begin
              ack_latched_nxt = 1'b0;
              if (!ack_hit) begin
                if (tick_expired) begin
                  ticks_nxt   = '0;
                  tmo_cnt_nxt = sat_inc16(tmo_cnt_r);
                end else begin
                  ticks_nxt = ticks_r - 16'd1;
                end
              end
              if (ack_hit || tick_expired) begin
                session_nxt = 1'b0;
                if (drop_close_r) begin
                  do_drop = 1'b1;
                end else begin
                  go_idle = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase

          // enable or command stage failed: retry, close session or drop
          if (stage_fail) begin
            if (retry_r < max_retries_r) begin
              retry_nxt = retry_r + 1'b1;
              send_en   = 1'b1;
            end else if (session_r) begin
              drop_close_nxt = 1'b1;
              send_dis       = 1'b1;
            end else begin
              do_drop = 1'b1;
            end
          end

          // drop the active command; word zero is not counted as a failure
          if (do_drop) begin
            if (active_r.word != '0) begin
              last_failed_nxt = active_r.word;
              fail_cnt_nxt    = sat_inc16(fail_cnt_r);
            end
            go_idle        = 1'b1;
            res.event_res  = EV_DROP;
            res.frame_word = active_r.word;
          end

          if (go_idle) begin
            has_active_nxt = 1'b0;
            drop_close_nxt = 1'b0;
            retry_nxt      = '0;
            expected_nxt   = '0;
            phase_nxt      = PH_IDLE;
          end

          if (send_en) begin
            expected_nxt   = ENABLE_ACK;
            ticks_nxt      = ack_timeout_r;
            phase_nxt      = PH_WAIT_EN;
            res.event_res  = EV_ENABLE;
            res.frame_word = ENABLE_ACK;
          end

          if (send_cmd) begin
            expected_nxt        = active_r.word | ACK_BIT;
            ticks_nxt           = ack_timeout_r;
            phase_nxt           = PH_WAIT_CMD;
            res.event_res       = EV_CMD;
            res.frame_word      = active_r.word;
            res.frame_value     = active_r.value;
            res.frame_has_value = active_r.has_value;
          end

          if (send_dis) begin
            expected_nxt   = DISABLE_ACK;
            ticks_nxt      = ack_timeout_r;
            phase_nxt      = PH_WAIT_DIS;
            res.event_res  = EV_DISABLE;
            res.frame_word = DISABLE_ACK;
          end
        end
        OP_ENQUEUE: begin
          fctl.push = 1'b1;
          if (fstat.full) begin
            overflow       = 1'b1;
            res.event_res  = EV_OVERFLOW;
            res.frame_word = fifo_head.word;
          end
        end
        OP_ACK: begin
          ack_latched_nxt = 1'b1;
          ack_word_nxt    = in_ack_word;
          ack_status_nxt  = in_ack_status;
        end
        default: begin
        end
      endcase
    end

    // counters and session flag as they stand after this request
    res.timeouts_seen    = tmo_cnt_nxt;
    res.failures_seen    = fail_cnt_nxt;
    res.last_failed_word = last_failed_nxt;
    res.session_open     = session_nxt;
    res_valid = send_en || send_cmd || send_dis || do_drop || overflow;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
      max_retries_r <= MAX_RETRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata;
        CFG_MAX_RETRIES: max_retries_r <= cfg_wdata[RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= '0;
      has_active_r  <= 1'b0;
      phase_r       <= PH_IDLE;
      retry_r       <= '0;
      session_r     <= 1'b0;
      drop_close_r  <= 1'b0;
      expected_r    <= '0;
      ticks_r       <= '0;
      ack_latched_r <= 1'b0;
      ack_word_r    <= '0;
      ack_status_r  <= '0;
      tmo_cnt_r     <= '0;
      fail_cnt_r    <= '0;
      last_failed_r <= '0;
    end else begin
      active_r      <= active_nxt;
      has_active_r  <= has_active_nxt;
      phase_r       <= phase_nxt;
      retry_r       <= retry_nxt;
      session_r     <= session_nxt;
      drop_close_r  <= drop_close_nxt;
      expected_r    <= expected_nxt;
      ticks_r       <= ticks_nxt;
      ack_latched_r <= ack_latched_nxt;
      ack_word_r    <= ack_word_nxt;
      ack_status_r  <= ack_status_nxt;
      tmo_cnt_r     <= tmo_cnt_nxt;
      fail_cnt_r    <= fail_cnt_nxt;
      last_failed_r <= last_failed_nxt;
    end
  end

  // output buffer: result register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && (!out_valid_r || out_take)) begin
      out_r <= res;
    end else if (!res_valid && out_take && skid_valid_r) begin
      out_r <= skid_r;
    end
    if (res_valid && out_valid_r && !out_take) begin
      skid_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_event_res        = out_r.event_res;
  assign out_frame_word       = out_r.frame_word;
  assign out_frame_value      = out_r.frame_value;
  assign out_frame_has_value  = out_r.frame_has_value;
  assign out_timeouts_seen    = out_r.timeouts_seen;
  assign out_failures_seen    = out_r.failures_seen;
  assign out_last_failed_word = out_r.last_failed_word;
  assign out_session_open     = out_r.session_open;

endmodule

### hw/rtl/ccts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccts_checker
// Port-level checks of the config command transaction sequencer, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "config_command_transaction_sequencer_macros.svh"

module ccts_checker
  import ccts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_event_res,
  input logic [15:0] out_frame_word,
  input logic [15:0] out_frame_value,
  input logic        out_frame_has_value,
  input logic        out_session_open
);

  // the input side only stalls while a result is waiting on the output
  `CCTS_ASSERT_SAME(a_stall_needs_result, clk, rst_n, in_stall, out_valid, "in_stall without pending result")

  // a stalled result stays put
  `CCTS_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_event_res) && $stable(out_frame_word), "stalled result changed")

  // enable frames carry the fixed enable word and no value
  `CCTS_ASSERT_SAME(a_enable_frame, clk, rst_n, out_valid && (out_event_res == EV_ENABLE), (out_frame_word == ENABLE_ACK) && !out_frame_has_value && (out_frame_value == '0), "bad enable frame")

  // a command frame only goes out inside an open session
  `CCTS_ASSERT_SAME(a_cmd_in_session, clk, rst_n, out_valid && (out_event_res == EV_CMD), out_session_open, "command frame with session closed")

endmodule

bind config_command_transaction_sequencer ccts_checker u_ccts_checker (.*);

### sim/config_command_transaction_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_command_transaction_sequencer_test
// Self-checking testbench. A behavioral model of the command queue and the
// enable / command / disable sequencer predicts each event, and every event
// taken from the block is compared field by field against the oldest one.
// Directed corner cases come first, then random well-formed command
// transactions with noise, random idling on both channels and back-pressure.
// ----------------------------------------------------------------------------
module config_command_transaction_sequencer_test;
  import ccts_pkg::*;

  localparam int          FIFO_DEPTH     = 4;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int          REQUEST_TARGET = 1950;
  localparam int          DRAIN_LIMIT    = 5000;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [15:0] in_cmd_word;
  logic [15:0] in_cmd_value;
  logic        in_cmd_has_value;
  logic [15:0] in_ack_word;
  logic [7:0]  in_ack_status;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_event_res;
  logic [15:0] out_frame_word;
  logic [15:0] out_frame_value;
  logic        out_frame_has_value;
  logic [15:0] out_timeouts_seen;
  logic [15:0] out_failures_seen;
  logic [15:0] out_last_failed_word;
  logic        out_session_open;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  config_command_transaction_sequencer dut (.*);

  // model state
  logic [15:0] cfg_timeout;
  logic [3:0]  cfg_retries;
  cmd_t        fifo_q [FIFO_DEPTH];
  int          fifo_head;
  int          fifo_count;
  cmd_t        cur_cmd;
  bit          cur_valid;
  phase_t      seq_phase;
  logic [3:0]  retries_used;
  bit          session_up;
  bit          close_then_drop;
  logic [15:0] want_ack;
  logic [15:0] ticks_remaining;
  bit          ack_pending;
  logic [15:0] ack_word_q;
  logic [7:0]  ack_status_q;
  logic [15:0] n_timeouts;
  logic [15:0] n_failures;
  logic [15:0] last_fail_word;

  result_t     expected_events [$];

  // bench control
  int          fail_count;
  int          requests_sent;
  int unsigned cycle_count;
  int          hold_off_len;
  bit          stall_mode;
  bit          sender_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** config_command_transaction_sequencer: FAILED **");
    $finish;
  end

  // idle lengths: mostly short, a few long
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // sequencer model
  // ---------------------------------------------------------------------------
  function automatic void post_event(event_t ev, logic [15:0] w, logic [15:0] v, logic hv);
    result_t r;
    r.event_res        = ev;
    r.frame_word       = w;
    r.frame_value      = v;
    r.frame_has_value  = hv;
    r.timeouts_seen    = n_timeouts;
    r.failures_seen    = n_failures;
    r.last_failed_word = last_fail_word;
    r.session_open     = session_up;
    expected_events.push_back(r);
  endfunction

  function automatic void launch_enable();
    want_ack        = ENABLE_ACK;
    ticks_remaining = cfg_timeout;
    seq_phase       = PH_WAIT_EN;
    post_event(EV_ENABLE, ENABLE_ACK, 16'h0, 1'b0);
  endfunction

  function automatic void launch_disable();
    want_ack        = DISABLE_ACK;
    ticks_remaining = cfg_timeout;
    seq_phase       = PH_WAIT_DIS;
    post_event(EV_DISABLE, DISABLE_ACK, 16'h0, 1'b0);
  endfunction

  function automatic void go_idle();
    cur_valid       = 1'b0;
    close_then_drop = 1'b0;
    retries_used    = 4'd0;
    want_ack        = 16'h0;
    seq_phase       = PH_IDLE;
  endfunction

  // a zero command word is dropped without counting as a failure
  function automatic void drop_current();
    if (cur_cmd.word != 16'h0) begin
      last_fail_word = cur_cmd.word;
      if (n_failures != 16'hFFFF) n_failures = n_failures + 16'd1;
    end
    go_idle();
    post_event(EV_DROP, cur_cmd.word, 16'h0, 1'b0);
  endfunction

  // enable or command stage failed: retry, close the session, or drop
  function automatic void stage_retry();
    if (retries_used < cfg_retries) begin
      retries_used = retries_used + 4'd1;
      launch_enable();
    end else if (session_up) begin
      close_then_drop = 1'b1;
      launch_disable();
    end else begin
      drop_current();
    end
  endfunction

  function automatic bit consume_ack(output logic [7:0] st);
    st = 8'h0;
    if (!ack_pending) return 1'b0;
    ack_pending = 1'b0;
    if (ack_word_q != want_ack) return 1'b0;
    st = ack_status_q;
    return 1'b1;
  endfunction

  // a timeout setting of zero behaves as one
  function automatic bit ack_timer_expired();
    if (ticks_remaining <= 16'd1) begin
      ticks_remaining = 16'h0;
      if (n_timeouts != 16'hFFFF) n_timeouts = n_timeouts + 16'd1;
      return 1'b1;
    end
    ticks_remaining = ticks_remaining - 16'd1;
    return 1'b0;
  endfunction

  function automatic void step_sequencer();
    logic [7:0] st;
    bit         hit;
    case (seq_phase)
      PH_IDLE: begin
        if (!cur_valid) begin
          if (fifo_count == 0) return;
          cur_cmd    = fifo_q[fifo_head];
          fifo_head  = (fifo_head + 1) % FIFO_DEPTH;
          fifo_count = fifo_count - 1;
        end
        cur_valid       = 1'b1;
        retries_used    = 4'd0;
        close_then_drop = 1'b0;
        launch_enable();
      end
      PH_WAIT_EN, PH_WAIT_CMD: begin
        if (consume_ack(st)) begin
          if (st != 8'h0) begin
            stage_retry();
          end else if (seq_phase == PH_WAIT_EN) begin
            session_up      = 1'b1;
            want_ack        = cur_cmd.word | ACK_BIT;
            ticks_remaining = cfg_timeout;
            seq_phase       = PH_WAIT_CMD;
            post_event(EV_CMD, cur_cmd.word, cur_cmd.value, cur_cmd.has_value);
          end else begin
            launch_disable();
          end
        end else if (ack_timer_expired()) begin
          stage_retry();
        end
      end
      default: begin
        // any matching ack closes the session, whatever its status
        hit = consume_ack(st);
        if (!hit) hit = ack_timer_expired();
        if (hit) begin
          session_up = 1'b0;
          if (close_then_drop) drop_current();
          else go_idle();
        end
      end
    endcase
  endfunction

  function automatic void model_request(logic [1:0] op, logic [15:0] word, logic [15:0] value,
                                        logic hv, logic [15:0] ackw, logic [7:0] acks);
    cmd_t entry;
    case (op)
      OP_TICK: step_sequencer();
      OP_ENQUEUE: begin
        entry.word      = word;
        entry.value     = value;
        entry.has_value = hv;
        // full queue: oldest entry is lost and reported
        if (fifo_count >= FIFO_DEPTH) begin
          post_event(EV_OVERFLOW, fifo_q[fifo_head].word, 16'h0, 1'b0);
          fifo_head  = (fifo_head + 1) % FIFO_DEPTH;
          fifo_count = FIFO_DEPTH - 1;
        end
        fifo_q[(fifo_head + fifo_count) % FIFO_DEPTH] = entry;
        fifo_count = fifo_count + 1;
      end
      OP_ACK: begin
        ack_word_q   = ackw;
        ack_status_q = acks;
        ack_pending  = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    cfg_timeout     = ACK_TIMEOUT_RST;
    cfg_retries     = MAX_RETRIES_RST;
    for (int i = 0; i < FIFO_DEPTH; i++) fifo_q[i] = '0;
    fifo_head       = 0;
    fifo_count      = 0;
    cur_cmd         = '0;
    cur_valid       = 1'b0;
    seq_phase       = PH_IDLE;
    retries_used    = 4'd0;
    session_up      = 1'b0;
    close_then_drop = 1'b0;
    want_ack        = 16'h0;
    ticks_remaining = 16'h0;
    ack_pending     = 1'b0;
    ack_word_q      = 16'h0;
    ack_status_q    = 8'h0;
    n_timeouts      = 16'h0;
    n_failures      = 16'h0;
    last_fail_word  = 16'h0;
  endfunction

  // ---------------------------------------------------------------------------
  // event checking
  // ---------------------------------------------------------------------------
  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, logic [15:0] got, logic [15:0] exp_v);
    if (got !== exp_v)
      report_failure($sformatf("%s expected %h actual %h", name, exp_v, got));
  endfunction

  always @(posedge clk) begin : event_checker
    result_t exp_ev;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_failure($sformatf("unexpected event %0d word %h", out_event_res,
                                 out_frame_word));
      end else begin
        exp_ev = expected_events.pop_front();
        check_field("event_res", 16'(out_event_res), 16'(exp_ev.event_res));
        check_field("frame_word", out_frame_word, exp_ev.frame_word);
        check_field("frame_value", out_frame_value, exp_ev.frame_value);
        check_field("frame_has_value", 16'(out_frame_has_value),
                    16'(exp_ev.frame_has_value));
        check_field("timeouts_seen", out_timeouts_seen, exp_ev.timeouts_seen);
        check_field("failures_seen", out_failures_seen, exp_ev.failures_seen);
        check_field("last_failed_word", out_last_failed_word, exp_ev.last_failed_word);
        check_field("session_open", 16'(out_session_open), 16'(exp_ev.session_open));
      end
    end
  end

  // event receiver: random stalls, plus a long hold-off on demand
  initial begin : event_receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        out_stall <= 1'b0;
      end else if (stall_mode && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_length()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic [15:0] word,
                              input logic [15:0] value, input logic hv,
                              input logic [15:0] ackw, input logic [7:0] acks);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_cmd_word      <= word;
    in_cmd_value     <= value;
    in_cmd_has_value <= hv;
    in_ack_word      <= ackw;
    in_ack_status    <= acks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_request(op, word, value, hv, ackw, acks);
    if (op != OP_UNUSED) requests_sent++;
  endtask

  // unused fields carry random noise
  task automatic send_tick();
    send_request(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
                 8'($urandom));
  endtask

  task automatic send_enqueue(input logic [15:0] w, input logic [15:0] v, input logic hv);
    send_request(OP_ENQUEUE, w, v, hv, 16'($urandom), 8'($urandom));
  endtask

  task automatic send_ack(input logic [15:0] w, input logic [7:0] s);
    send_request(OP_ACK, 16'($urandom), 16'($urandom), 1'($urandom), w, s);
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == CFG_ACK_TIMEOUT) cfg_timeout = data;
    else cfg_retries = data[3:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every outstanding event arrive
  task automatic wait_drain();
    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_events.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // queue commands, then tick the sequencer through them while answering acks
  task automatic run_commands(input int n_cmds, input int ack_pct, input bit clean);
    int          guard;
    logic [15:0] w;
    logic [7:0]  s;
    for (int i = 0; i < n_cmds; i++)
      send_enqueue(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
    guard = 0;
    while ((cur_valid || fifo_count != 0) && guard < 300) begin
      guard++;
      if (!clean && $urandom_range(0, 11) == 0)
        send_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                     1'($urandom), 16'($urandom), 8'($urandom));
      if (seq_phase != PH_IDLE && $urandom_range(1, 100) <= ack_pct) begin
        w = want_ack;
        if (!clean) begin
          case ($urandom_range(0, 9))
            0: w = 16'($urandom);
            1: w = want_ack ^ (16'h1 << $urandom_range(0, 15));
            default: ;
          endcase
        end
        if ($urandom_range(0, 99) < 85) s = 8'h00;
        else s = 8'($urandom_range(1, 255));
        send_ack(w, s);
      end
      send_tick();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty ticks, unused opcode, ack latched in idle, discard and retry paths
  task automatic test_idle_corners();
    send_tick();
    send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF);
    send_ack(ENABLE_ACK, 8'h80);
    send_ack(ENABLE_ACK, 8'h00);
    send_enqueue(16'hFFFF, 16'hFFFF, 1'b1);
    send_tick();
    send_tick();
    send_ack(16'h1234, 8'h00);
    send_tick();
    send_ack(16'hFFFF, 8'hFF);
    send_tick();
    send_ack(ENABLE_ACK, 8'h00);
    send_tick();
    send_ack(16'hFFFF, 8'h00);
    send_tick();
    send_ack(DISABLE_ACK, 8'h01);
    send_tick();
    wait_drain();
  endtask

  // fifth enqueue pushes out the oldest command
  task automatic test_queue_overflow();
    send_enqueue(16'h7777, 16'h0000, 1'b0);
    send_enqueue(16'h0000, 16'h5555, 1'b1);
    send_enqueue(16'h00FF, 16'hAAAA, 1'b0);
    send_enqueue(16'h8000, 16'h0000, 1'b0);
    send_enqueue(16'hFE01, 16'h0001, 1'b1);
    wait_drain();
  endtask

  // zero timeout, no retries: drops with and without an open session
  task automatic test_short_timeout();
    cfg_write(CFG_ACK_TIMEOUT, 16'h0000);
    cfg_write(CFG_MAX_RETRIES, 16'h0000);
    while (cur_valid || fifo_count != 0) send_tick();
    wait_drain();
    cfg_write(CFG_ACK_TIMEOUT, 16'h0001);
    send_enqueue(16'h0C0C, 16'h1111, 1'b1);
    send_tick();
    send_ack(ENABLE_ACK, 8'h00);
    send_tick();
    send_tick();
    send_tick();
    wait_drain();
  endtask

  // longest timeout and largest retry budget, every ack delivered
  task automatic test_max_timeout();
    cfg_write(CFG_ACK_TIMEOUT, 16'hFFFF);
    cfg_write(CFG_MAX_RETRIES, 16'hFFFF);
    run_commands(3, 100, 1'b1);
    wait_drain();
  endtask

  // receiver holds off while requests keep coming, until the input stalls
  task automatic test_backpressure();
    stall_mode  = 1'b0;
    sender_gaps = 1'b0;
    hold_off_len = 300;
    while (!out_stall) @(posedge clk);
    for (int i = 0; i < 16; i++)
      send_enqueue(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
    for (int i = 0; i < 8; i++) send_tick();
    wait_drain();
  endtask

  // random settings per phase, random transactions with noise
  task automatic test_random_traffic();
    logic [15:0] t;
    logic [15:0] r;
    bit          clean;
    while (requests_sent < REQUEST_TARGET) begin
      wait_drain();
      case ($urandom_range(0, 9))
        0:       t = 16'h0000;
        1:       t = 16'hFFFF;
        2, 3:    t = 16'($urandom_range(5, 12));
        default: t = 16'($urandom_range(1, 4));
      endcase
      clean = (t > 16'd12);
      r = 16'($urandom);
      cfg_write(CFG_ACK_TIMEOUT, t);
      cfg_write(CFG_MAX_RETRIES, r);
      stall_mode  = ($urandom_range(0, 4) != 0);
      sender_gaps = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(4, 10)) begin
        if (requests_sent < REQUEST_TARGET)
          run_commands($urandom_range(1, 6), clean ? 100 : $urandom_range(40, 95), clean);
      end
    end
    wait_drain();
  endtask

  initial begin : main_sequence
    fail_count    = 0;
    requests_sent = 0;
    hold_off_len  = 0;
    stall_mode    = 1'b1;
    sender_gaps   = 1'b1;
    reset_model();
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_opcode        <= OP_TICK;
    in_cmd_word      <= 16'h0;
    in_cmd_value     <= 16'h0;
    in_cmd_has_value <= 1'b0;
    in_ack_word      <= 16'h0;
    in_ack_status    <= 8'h0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ACK_TIMEOUT;
    cfg_wdata        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_corners();
    test_queue_overflow();
    test_short_timeout();
    test_max_timeout();
    test_backpressure();
    test_random_traffic();

    repeat (8) @(posedge clk);
    if (expected_events.size() != 0)
      report_failure($sformatf("%0d events never arrived", expected_events.size()));
    if (fail_count == 0) begin
      $display("** config_command_transaction_sequencer: PASSED **");
    end else begin
      $display("** config_command_transaction_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
